/* sv/lrs_pkg.sv */
// ----------------------------------------------------------------------------
// lrs_pkg
// Shared constants, payload types and controller/datapath links of the
// addressable RGB LED serializer.
// ----------------------------------------------------------------------------
package lrs_pkg;

  // Defaults for the top level parameters
  localparam int MaxLedsDefault      = 256;
  localparam int ResetPeriodsDefault = 45;

  // Field widths
  localparam int ActionW   = 3;
  localparam int IndexW    = 8;
  localparam int ColorW    = 8;
  localparam int PeriodW   = 10;
  localparam int LedCountW = 9;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 10;
  localparam int PixelW    = 3 * ColorW;
  localparam int BitPtrW   = 5;

  localparam logic [BitPtrW-1:0] LastBit = BitPtrW'(PixelW - 1);

  // Register reset values
  localparam logic [PeriodW-1:0]   PeriodReset   = PeriodW'(300);
  localparam logic [LedCountW-1:0] LedCountReset = LedCountW'(1);

  // x / 25 for x below 2**14: (x * Div25Recip) >> Div25Shift
  localparam int Div25Recip = 20972;
  localparam int Div25Shift = 19;
  localparam int ProdW      = 29;

  // Action codes
  localparam logic [ActionW-1:0] ACT_TICK      = 3'd0;
  localparam logic [ActionW-1:0] ACT_SET_PIXEL = 3'd1;
  localparam logic [ActionW-1:0] ACT_SET_ALL   = 3'd2;
  localparam logic [ActionW-1:0] ACT_CLEAR     = 3'd3;
  localparam logic [ActionW-1:0] ACT_SHOW      = 3'd4;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_PERIOD    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LED_COUNT = 2'd1;

  typedef struct packed {
    logic [ActionW-1:0] action;
    logic [IndexW-1:0]  led_index;
    logic [ColorW-1:0]  red;
    logic [ColorW-1:0]  green;
    logic [ColorW-1:0]  blue;
  } act_item_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic accepted;
  } res_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  reg_idx;
    logic [CfgDataW-1:0] wr_data;
  } cfg_wr_t;

  // Controller to datapath
  typedef struct packed {
    logic set_pix;
    logic fill_start;
    logic fill_zero;
    logic sweep_wr;
    logic frame_start;
    logic tick;
    logic ph_reset;
    logic ph_data;
    logic ph_tail;
  } lrs_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic period_end;
    logic reset_done;
    logic data_done;
    logic n_zero;
    logic sweep_last;
    logic pc_lt_duty;
  } lrs_sts_t;

endpackage

/* sv/lrs_if.sv */
// ----------------------------------------------------------------------------
// lrs_if
// Valid/ready channels of the LED serializer: action items, results and
// configuration writes.
// ----------------------------------------------------------------------------
interface lrs_act_if
  import lrs_pkg::*;
;
  logic      valid;
  logic      ready;
  act_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lrs_res_if
  import lrs_pkg::*;
;
  logic      valid;
  logic      ready;
  res_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lrs_cfg_if
  import lrs_pkg::*;
;
  logic    valid;
  logic    ready;
  cfg_wr_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/lrs_datapath.sv */
// ----------------------------------------------------------------------------
// lrs_datapath
// Pixel memory, fill sweep, bit period timer, frame counters, duty values
// and configuration registers.
// ----------------------------------------------------------------------------
module lrs_datapath
  import lrs_pkg::*;
#(
  parameter int MAX_LEDS      = MaxLedsDefault,
  parameter int RESET_PERIODS = ResetPeriodsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_fire_i,
  input  cfg_wr_t   cfg_i,
  input  act_item_t item_i,
  input  lrs_cmd_t  cmd_i,
  output lrs_sts_t  sts_o
);

  localparam int AW  = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int LW  = $clog2(MAX_LEDS + 1);
  localparam int RPW = (RESET_PERIODS > 0) ? $clog2(RESET_PERIODS + 1) : 1;

  logic [PeriodW-1:0]   period_q;
  logic [LedCountW-1:0] led_count_q;

  logic [PixelW-1:0] mem [MAX_LEDS];
  logic [PixelW-1:0] rdata_q;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [AW-1:0]     mem_raddr;
  logic [PixelW-1:0] mem_wdata;

  logic [LW-1:0]     sweep_cnt_q;
  logic [LW-1:0]     sweep_lim_q;
  logic [PixelW-1:0] fill_q;

  logic [PeriodW-1:0] pc_q;
  logic [RPW-1:0]     lpc_q;
  logic [LW-1:0]      led_q;
  logic [BitPtrW-1:0] bit_q;
  logic [PeriodW-1:0] duty_q;
  logic [PixelW-1:0]  cur_pix_q;

  logic [PeriodW-1:0] duty0;
  logic [PeriodW-1:0] duty1;
  logic [ProdW-1:0]   prod0;
  logic [ProdW-1:0]   prod1;

  logic [LW-1:0]      n_active;
  logic [PixelW-1:0]  grb;
  logic               idx_ok;
  logic [PeriodW-1:0] pc_inc;
  logic               period_end;
  logic               reset_done;
  logic               led_adv;
  logic [LW-1:0]      led_new;
  logic [BitPtrW-1:0] bit_new;
  logic               data_done;
  logic [PixelW-1:0]  word_new;
  logic [BitPtrW-1:0] sel_new;
  logic [BitPtrW-1:0] sel_first;
  logic [PeriodW-1:0] duty_new;
  logic [PeriodW-1:0] duty_first;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= PeriodReset;
      led_count_q <= LedCountReset;
    end else if (cfg_fire_i) begin
      unique case (cfg_i.reg_idx)
        CFG_PERIOD:    period_q    <= cfg_i.wr_data[PeriodW-1:0];
        CFG_LED_COUNT: led_count_q <= cfg_i.wr_data[LedCountW-1:0];
        default: ;
      endcase
    end
  end

  assign n_active = (32'(led_count_q) < 32'(MAX_LEDS)) ? LW'(led_count_q) : LW'(MAX_LEDS);
  assign grb      = {item_i.green, item_i.red, item_i.blue};
  assign idx_ok   = 32'(item_i.led_index) < 32'(n_active);

  // Duty values for a 0 bit (period*8/25) and a 1 bit (period*16/25), taken
  // from the period register as it stands when a bit is loaded
  assign prod0 = {16'b0, period_q, 3'b000} * ProdW'(Div25Recip);
  assign prod1 = {15'b0, period_q, 4'b0000} * ProdW'(Div25Recip);
  assign duty0 = prod0[Div25Shift +: PeriodW];
  assign duty1 = prod1[Div25Shift +: PeriodW];

  // Pixel memory: one write port, one registered read port
  assign mem_we    = cmd_i.sweep_wr | (cmd_i.set_pix & idx_ok);
  assign mem_waddr = cmd_i.sweep_wr ? AW'(sweep_cnt_q) : AW'(item_i.led_index);
  assign mem_wdata = cmd_i.sweep_wr ? fill_q : grb;
  // Prefetch the next pixel while the current one is shifted out
  assign mem_raddr = cmd_i.ph_data ? AW'(led_q + LW'(1)) : '0;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  // Fill sweep; after reset it clears the whole memory
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_cnt_q <= '0;
      sweep_lim_q <= LW'(MAX_LEDS);
      fill_q      <= '0;
    end else if (cmd_i.fill_start) begin
      sweep_cnt_q <= '0;
      sweep_lim_q <= n_active;
      fill_q      <= cmd_i.fill_zero ? '0 : grb;
    end else if (cmd_i.sweep_wr) begin
      sweep_cnt_q <= sweep_cnt_q + LW'(1);
    end
  end

  // Bit period timer and frame counters
  assign pc_inc     = pc_q + PeriodW'(1);
  assign period_end = (pc_inc >= period_q) || (pc_inc == '0);
  assign reset_done = lpc_q == RPW'(RESET_PERIODS);
  assign led_adv    = bit_q == LastBit;
  assign bit_new    = led_adv ? '0 : bit_q + BitPtrW'(1);
  assign led_new    = led_adv ? led_q + LW'(1) : led_q;
  assign data_done  = led_new >= n_active;
  assign word_new   = led_adv ? rdata_q : cur_pix_q;
  assign sel_new    = LastBit - bit_new;
  assign sel_first  = LastBit;
  assign duty_new   = word_new[sel_new] ? duty1 : duty0;
  assign duty_first = rdata_q[sel_first] ? duty1 : duty0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= '0;
      lpc_q  <= '0;
      led_q  <= '0;
      bit_q  <= '0;
      duty_q <= '0;
    end else if (cmd_i.frame_start) begin
      pc_q   <= '0;
      lpc_q  <= '0;
      led_q  <= '0;
      bit_q  <= '0;
      duty_q <= '0;
    end else if (cmd_i.tick) begin
      if (!period_end) begin
        pc_q <= pc_inc;
      end else begin
        pc_q <= '0;
        if (cmd_i.ph_reset) begin
          if (reset_done) begin
            lpc_q  <= '0;
            led_q  <= '0;
            bit_q  <= '0;
            duty_q <= (n_active == '0) ? '0 : duty_first;
          end else begin
            lpc_q <= lpc_q + RPW'(1);
          end
        end else if (cmd_i.ph_data) begin
          led_q  <= led_new;
          bit_q  <= bit_new;
          duty_q <= data_done ? '0 : duty_new;
        end else if (cmd_i.ph_tail) begin
          led_q  <= '0;
          bit_q  <= '0;
          duty_q <= '0;
        end
      end
    end
  end

  // Current pixel word; memory content only
  always_ff @(posedge clk_i) begin
    if (cmd_i.tick && period_end) begin
      if (cmd_i.ph_reset && reset_done) begin
        cur_pix_q <= rdata_q;
      end else if (cmd_i.ph_data) begin
        cur_pix_q <= word_new;
      end
    end
  end

  assign sts_o.period_end = period_end;
  assign sts_o.reset_done = reset_done;
  assign sts_o.data_done  = data_done;
  assign sts_o.n_zero     = n_active == '0;
  assign sts_o.sweep_last = (sweep_cnt_q + LW'(1)) >= sweep_lim_q;
  assign sts_o.pc_lt_duty = pc_q < duty_q;

endmodule

/* sv/lrs_ctrl.sv */
// ----------------------------------------------------------------------------
// lrs_ctrl
// Frame and sweep state machine, input handshake and result register.
// ----------------------------------------------------------------------------
module lrs_ctrl
  import lrs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [ActionW-1:0] in_action_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output res_item_t          out_data_o,
  input  lrs_sts_t           sts_i,
  output lrs_cmd_t           cmd_o
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_FILL  = 3'd2;
  localparam logic [2:0] S_RESET = 3'd3;
  localparam logic [2:0] S_DATA  = 3'd4;
  localparam logic [2:0] S_TAIL  = 3'd5;

  logic [2:0] state_q;
  logic [2:0] state_d;
  logic       out_valid_q;
  res_item_t  out_data_q;
  logic       in_fire;
  logic       busy;
  logic       busy_next;
  logic       acc;

  assign in_ready_o = (state_q != S_CLEAR) && (state_q != S_FILL) &&
                      (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;
  assign busy       = (state_q == S_RESET) || (state_q == S_DATA) || (state_q == S_TAIL);
  assign busy_next  = (state_d == S_RESET) || (state_d == S_DATA) || (state_d == S_TAIL);

  always_comb begin
    state_d          = state_q;
    acc              = 1'b0;
    cmd_o            = '0;
    cmd_o.ph_reset   = state_q == S_RESET;
    cmd_o.ph_data    = state_q == S_DATA;
    cmd_o.ph_tail    = state_q == S_TAIL;
    unique case (state_q)
      S_CLEAR, S_FILL: begin
        cmd_o.sweep_wr = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_action_i)
            ACT_TICK: begin
              acc = 1'b1;
            end
            ACT_SET_PIXEL: begin
              acc           = 1'b1;
              cmd_o.set_pix = 1'b1;
            end
            ACT_SET_ALL, ACT_CLEAR: begin
              acc = 1'b1;
              if (!sts_i.n_zero) begin
                cmd_o.fill_start = 1'b1;
                cmd_o.fill_zero  = in_action_i == ACT_CLEAR;
                state_d          = S_FILL;
              end
            end
            ACT_SHOW: begin
              acc               = 1'b1;
              cmd_o.frame_start = 1'b1;
              state_d           = S_RESET;
            end
            default: begin
              acc = 1'b0;
            end
          endcase
        end
      end
      S_RESET, S_DATA, S_TAIL: begin
        // Only ticks go through while a frame is out
        if (in_fire && in_action_i == ACT_TICK) begin
          acc        = 1'b1;
          cmd_o.tick = 1'b1;
          if (sts_i.period_end) begin
            if (state_q == S_RESET) begin
              if (sts_i.reset_done) begin
                state_d = sts_i.n_zero ? S_TAIL : S_DATA;
              end
            end else if (state_q == S_DATA) begin
              if (sts_i.data_done) begin
                state_d = S_TAIL;
              end
            end else begin
              state_d = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q.line_level <= busy && sts_i.pc_lt_duty;
      out_data_q.busy_res   <= busy_next;
      out_data_q.accepted   <= acc;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* sv/addressable_rgb_led_serializer_core.sv */
// ----------------------------------------------------------------------------
// addressable_rgb_led_serializer_core
// Single-wire RGB LED chain driver: pixel store, set/fill/clear actions and
// a frame serializer advanced by one timer clock per tick action.
// ----------------------------------------------------------------------------
//  channel    dir  payload                                   transfer when
//  in_ch_i    in   action, led_index, red, green, blue       valid & ready
//  out_ch_o   out  line_level, busy_res, accepted            valid & ready
//  cfg_ch_i   in   reg_idx (0 period_ticks, 1 led_count),    valid & ready
//                  wr_data                                   (always ready)
//
//  Ticks, set pixel, show and rejected actions each finish on their transfer; the
//  result lands in a register and the next transfer is taken as it leaves.
//  Set all and clear write one memory entry per cycle over the active LEDs.
//  After reset the pixel memory is cleared one entry a cycle with the input
//  held off; configuration writes are taken meanwhile.
//  A stalled result holds the input off; nothing is dropped.
// ----------------------------------------------------------------------------
module addressable_rgb_led_serializer_core
  import lrs_pkg::*;
#(
  parameter int MAX_LEDS      = MaxLedsDefault,
  parameter int RESET_PERIODS = ResetPeriodsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lrs_act_if.sink   in_ch_i,
  lrs_res_if.source out_ch_o,
  lrs_cfg_if.sink   cfg_ch_i
);

  lrs_cmd_t  cmd;
  lrs_sts_t  sts;
  res_item_t out_data;
  logic      out_valid;
  logic      in_ready;

  // Registers are plain flops, so configuration never stalls
  assign cfg_ch_i.ready = 1'b1;

  assign in_ch_i.ready  = in_ready;
  assign out_ch_o.valid = out_valid;
  assign out_ch_o.data  = out_data;

  // Controller: action decode, frame phase, sweep sequencing, result register
  lrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch_i.valid),
    .in_action_i (in_ch_i.data.action),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_ch_o.ready),
    .out_data_o  (out_data),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: pixel memory, period timer, bit/LED pointers, duty values
  lrs_datapath #(
    .MAX_LEDS      (MAX_LEDS),
    .RESET_PERIODS (RESET_PERIODS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_fire_i (cfg_ch_i.valid && cfg_ch_i.ready),
    .cfg_i      (cfg_ch_i.data),
    .item_i     (in_ch_i.data),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the LED chain serializer. A directed walk covers
// idle and busy refusals, unknown actions, out-of-range pixel writes, a zero
// LED count, a count beyond the store depth and the longest bit period
// setting; random frames with noise follow. Every result is checked against
// its planned value or an in-bench frame timer.
// ----------------------------------------------------------------------------
module tb;
  import lrs_pkg::*;

  localparam int MaxLeds      = MaxLedsDefault;
  localparam int RstPeriods   = ResetPeriodsDefault;
  localparam int RandomItems  = 700;
  localparam int MaxShowLeds  = 4;
  localparam int CycleLimit   = 4_000_000;
  localparam int LongHold     = 400;
  localparam int SettleCycles = 2;
  localparam int TailCycles   = 16;
  localparam int MaxPrints    = 20;

  // Duty of one bit period, in percent of the period
  localparam int DutyZero  = 32;
  localparam int DutyOne   = 64;
  localparam int DutyScale = 100;

  // Action codes the block must refuse
  localparam logic [ActionW-1:0] ACT_UNUSED_LO  = 3'd5;
  localparam logic [ActionW-1:0] ACT_UNUSED_MID = 3'd6;
  localparam logic [ActionW-1:0] ACT_UNUSED_HI  = 3'd7;

  // Results that can be read straight off the action: {line, busy, accepted}
  localparam res_item_t ResIdleTaken   = '{1'b0, 1'b0, 1'b1};
  localparam res_item_t ResIdleRefused = '{1'b0, 1'b0, 1'b0};
  localparam res_item_t ResBusyTaken   = '{1'b0, 1'b1, 1'b1};
  localparam res_item_t ResBusyRefused = '{1'b0, 1'b1, 1'b0};

  typedef enum logic [1:0] {FRM_IDLE, FRM_RESET, FRM_DATA, FRM_TAIL} frame_phase_e;
  typedef enum logic [1:0] {ROW_ACTION, ROW_SETTINGS, ROW_FINISH_FRAME} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    act_item_t   item;
    res_item_t   want;
    int unsigned period;
    int unsigned leds;
  } plan_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  lrs_act_if act_ch ();
  lrs_res_if res_ch ();
  lrs_cfg_if cfg_ch ();

  addressable_rgb_led_serializer_core #(
    .MAX_LEDS      (MaxLeds),
    .RESET_PERIODS (RstPeriods)
  ) DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch_i  (act_ch),
    .out_ch_o (res_ch),
    .cfg_ch_i (cfg_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Frame timer: pixel store, registers and serializer state
  // --------------------------------------------------------------------------
  logic [PixelW-1:0] strip_px [MaxLeds];
  int unsigned       cfg_period  = PeriodReset;
  int unsigned       cfg_leds    = LedCountReset;
  frame_phase_e      frm_phase   = FRM_IDLE;
  int unsigned       bit_timer   = 0;
  int unsigned       low_periods = 0;
  int unsigned       px_ptr      = 0;
  int unsigned       bit_ptr     = 0;
  int unsigned       duty_ticks  = 0;

  // Expected line/busy/accept results, oldest first
  res_item_t   led_results_q [$];
  plan_row_t   plan_q [$];
  int unsigned errors         = 0;
  int unsigned results_seen   = 0;
  int unsigned sent_items     = 0;
  int unsigned burst_left     = 0;
  int unsigned cycle_count    = 0;
  logic        hold_res       = 1'b0;
  logic        frame_drain_on = 1'b0;

  initial begin
    foreach (strip_px[i]) strip_px[i] = '0;
  end

  // LEDs that a frame or a fill covers: the count, capped at the store depth
  function automatic int unsigned lit_leds();
    return (cfg_leds < MaxLeds) ? cfg_leds : MaxLeds;
  endfunction

  // Fetch the next bit (G, R, B, MSB first) and derive its high time
  function automatic void load_duty();
    logic [PixelW-1:0] px;
    px = (px_ptr < MaxLeds) ? strip_px[px_ptr] : '0;
    duty_ticks = (cfg_period * (px[PixelW-1-bit_ptr] ? DutyOne : DutyZero)) / DutyScale;
  endfunction

  function automatic res_item_t step_led_frame(input act_item_t it);
    res_item_t   r;
    logic        busy;
    int unsigned n;
    int unsigned i;
    busy         = frm_phase != FRM_IDLE;
    r.line_level = busy && (bit_timer < duty_ticks);
    r.accepted   = 1'b0;
    if (it.action == ACT_TICK) begin
      r.accepted = 1'b1;
      if (busy) begin
        // the timer wraps at its width; a zero period still ends on every tick
        bit_timer = (bit_timer + 1) % (1 << PeriodW);
        if (bit_timer >= cfg_period || bit_timer == 0) begin
          bit_timer = 0;
          case (frm_phase)
            FRM_RESET: begin
              low_periods++;
              if (low_periods >= RstPeriods + 1) begin
                low_periods = 0;
                px_ptr      = 0;
                bit_ptr     = 0;
                if (lit_leds() == 0) begin
                  frm_phase  = FRM_TAIL;
                  duty_ticks = 0;
                end else begin
                  frm_phase = FRM_DATA;
                  load_duty();
                end
              end
            end
            FRM_DATA: begin
              bit_ptr++;
              if (bit_ptr >= PixelW) begin
                bit_ptr = 0;
                px_ptr++;
              end
              if (px_ptr >= lit_leds()) begin
                frm_phase  = FRM_TAIL;
                duty_ticks = 0;
              end else begin
                load_duty();
              end
            end
            default: begin
              frm_phase  = FRM_IDLE;
              duty_ticks = 0;
              px_ptr     = 0;
              bit_ptr    = 0;
            end
          endcase
        end
      end
    end else if (!busy && it.action <= ACT_SHOW) begin
      r.accepted = 1'b1;
      n          = lit_leds();
      case (it.action)
        ACT_SET_PIXEL: begin
          if (it.led_index < n) strip_px[it.led_index] = {it.green, it.red, it.blue};
        end
        ACT_SET_ALL, ACT_CLEAR: begin
          for (i = 0; i < n; i++) begin
            strip_px[i] = (it.action == ACT_SET_ALL) ? {it.green, it.red, it.blue} : '0;
          end
        end
        ACT_SHOW: begin
          frm_phase    = FRM_RESET;
          bit_timer    = 0;
          low_periods  = 0;
          px_ptr       = 0;
          bit_ptr      = 0;
          duty_ticks   = 0;
          r.line_level = 1'b0;
        end
        default: ;
      endcase
    end
    r.busy_res = frm_phase != FRM_IDLE;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus builders
  // --------------------------------------------------------------------------
  function automatic act_item_t any_item(input logic [ActionW-1:0] act);
    act_item_t it;
    it.action    = act;
    it.led_index = IndexW'($urandom_range(0, 255));
    it.red       = ColorW'($urandom_range(0, 255));
    it.green     = ColorW'($urandom_range(0, 255));
    it.blue      = ColorW'($urandom_range(0, 255));
    return it;
  endfunction

  // Store edits ahead of a frame, with a few idle ticks and unknown codes mixed in
  function automatic act_item_t store_item();
    act_item_t   it;
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 11) it = any_item(ACT_SET_PIXEL);
    else if (pick < 14) it = any_item(ACT_SET_ALL);
    else if (pick < 16) it = any_item(ACT_CLEAR);
    else if (pick < 18) it = any_item(ACT_TICK);
    else it = any_item(ActionW'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI)));
    // aim most pixel writes inside the chain so that frames carry them
    if (pick < 8 && lit_leds() != 0) it.led_index = IndexW'($urandom_range(0, lit_leds() - 1));
    return it;
  endfunction

  function automatic plan_row_t plan_action(input logic [ActionW-1:0] act,
                                            input logic [IndexW-1:0]  idx,
                                            input logic [PixelW-1:0]  grb,
                                            input res_item_t          want);
    plan_row_t row;
    row.kind           = ROW_ACTION;
    row.item.action    = act;
    row.item.led_index = idx;
    {row.item.green, row.item.red, row.item.blue} = grb;
    row.want   = want;
    row.period = 0;
    row.leds   = 0;
    return row;
  endfunction

  function automatic plan_row_t plan_settings(input int unsigned period, input int unsigned leds);
    plan_row_t row;
    row.kind   = ROW_SETTINGS;
    row.item   = '0;
    row.want   = '0;
    row.period = period;
    row.leds   = leds;
    return row;
  endfunction

  function automatic plan_row_t plan_finish();
    plan_row_t row;
    row = plan_settings(0, 0);
    row.kind = ROW_FINISH_FRAME;
    return row;
  endfunction

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------
  // Offer one action and hold it until the transfer; log what must come back.
  // Bursts of random length with random gaps shape the offer rate.
  task automatic push_action(input act_item_t it, input logic typed, input res_item_t want);
    int unsigned gap;
    res_item_t   got_model;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        act_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    act_ch.valid <= 1'b1;
    act_ch.data  <= it;
    do @(posedge clk_i); while (!act_ch.ready);
    got_model = step_led_frame(it);
    led_results_q.push_back(typed ? want : got_model);
    sent_items++;
  endtask

  // Drop the action channel, let the results drain, then write both registers
  task automatic load_settings(input int unsigned period, input int unsigned leds);
    act_ch.valid <= 1'b0;
    while (led_results_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= '{reg_idx: CFG_PERIOD, wr_data: CfgDataW'(period)};
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_period = period;
    cfg_ch.data <= '{reg_idx: CFG_LED_COUNT, wr_data: CfgDataW'(leds)};
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_leds = leds;
    cfg_ch.valid <= 1'b0;
  endtask

  // Tick until the frame ends; sprinkle in actions that a busy block refuses
  task automatic finish_frame(input int unsigned noise_pct);
    while (frm_phase != FRM_IDLE) begin
      if ($urandom_range(0, 99) < noise_pct)
        push_action(any_item(ActionW'($urandom_range(ACT_SET_PIXEL, ACT_UNUSED_HI))), 1'b0, '0);
      else
        push_action(any_item(ACT_TICK), 1'b0, '0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: stall pattern, long hold-off and checking
  // --------------------------------------------------------------------------
  // Alternate between always ready, a rotating mask and biased coin flips
  initial begin : res_ready_drive
    logic [7:0]  mask;
    int unsigned mode;
    int unsigned stretch;
    forever begin
      mode    = $urandom_range(0, 2);
      stretch = $urandom_range(16, 200);
      mask    = 8'($urandom_range(0, 255)) | 8'd1;
      repeat (stretch) begin
        @(posedge clk_i);
        mask = {mask[6:0], mask[7]};
        case (mode)
          0:       res_ch.ready <= !hold_res;
          1:       res_ch.ready <= !hold_res && mask[0];
          default: res_ch.ready <= !hold_res && ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Hold results off for a long stretch in the first two frame drains, while
  // ticks keep coming, so the block backs up into its input
  initial begin : res_hold_off
    repeat (2) begin
      wait (frame_drain_on);
      repeat ($urandom_range(5, 40)) @(posedge clk_i);
      hold_res <= 1'b1;
      repeat (LongHold) @(posedge clk_i);
      hold_res <= 1'b0;
      wait (!frame_drain_on);
    end
  end

  task automatic note_mismatch(input string what);
    if (errors < MaxPrints) $display("tb: mismatch: %s", what);
    errors++;
  endtask

  task automatic check_field(input string name, input logic got, input logic want);
    if (got !== want)
      note_mismatch($sformatf("result %0d %s got %b want %b", results_seen, name, got, want));
  endtask

  always @(posedge clk_i) begin : check_results
    res_item_t want;
    if (rst_ni && res_ch.valid === 1'b1 && res_ch.ready) begin
      if (led_results_q.size() == 0) begin
        note_mismatch($sformatf("result %0d arrived with nothing outstanding", results_seen));
      end else begin
        want = led_results_q.pop_front();
        check_field("line_level", res_ch.data.line_level, want.line_level);
        check_field("busy_res", res_ch.data.busy_res, want.busy_res);
        check_field("accepted", res_ch.data.accepted, want.accepted);
      end
      results_seen++;
    end
  end

  // Stop a hung run
  initial begin : watchdog
    do begin
      @(posedge clk_i);
      cycle_count++;
    end while (cycle_count < CycleLimit);
    $display("tb: failure");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    int unsigned mark;
    int unsigned per;
    int unsigned leds;
    int unsigned pick;
    act_ch.valid = 1'b0;
    act_ch.data  = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    res_ch.ready = 1'b0;

    // Idle behavior at reset settings (period 300, one LED)
    plan_q.push_back(plan_action(ACT_TICK, 8'd0, 24'h000000, ResIdleTaken));
    plan_q.push_back(plan_action(ACT_UNUSED_LO, 8'd0, 24'h000000, ResIdleRefused));
    plan_q.push_back(plan_action(ACT_UNUSED_HI, 8'd255, 24'hFFFFFF, ResIdleRefused));
    plan_q.push_back(plan_action(ACT_SET_PIXEL, 8'd0, 24'hFF00AA, ResIdleTaken));
    // index beyond the chain: taken, writes nothing
    plan_q.push_back(plan_action(ACT_SET_PIXEL, 8'd255, 24'hFFFFFF, ResIdleTaken));
    // Short frame; everything but a tick is refused while it runs
    plan_q.push_back(plan_settings(4, 1));
    plan_q.push_back(plan_action(ACT_SHOW, 8'd0, 24'h000000, ResBusyTaken));
    plan_q.push_back(plan_action(ACT_SET_PIXEL, 8'd0, 24'h000000, ResBusyRefused));
    plan_q.push_back(plan_action(ACT_SET_ALL, 8'd0, 24'hFFFFFF, ResBusyRefused));
    plan_q.push_back(plan_action(ACT_CLEAR, 8'd0, 24'h000000, ResBusyRefused));
    plan_q.push_back(plan_action(ACT_SHOW, 8'd0, 24'h000000, ResBusyRefused));
    plan_q.push_back(plan_action(ACT_UNUSED_MID, 8'd9, 24'h123456, ResBusyRefused));
    plan_q.push_back(plan_action(ACT_TICK, 8'd0, 24'h000000, ResBusyTaken));
    plan_q.push_back(plan_finish());
    // Empty chain: fills change nothing, frame skips the data bits
    plan_q.push_back(plan_settings(1, 0));
    plan_q.push_back(plan_action(ACT_SET_ALL, 8'd0, 24'hFFFFFF, ResIdleTaken));
    plan_q.push_back(plan_action(ACT_CLEAR, 8'd0, 24'h000000, ResIdleTaken));
    plan_q.push_back(plan_action(ACT_SHOW, 8'd0, 24'h000000, ResBusyTaken));
    plan_q.push_back(plan_finish());
    // Count above the store depth: fills and writes reach the last entry
    plan_q.push_back(plan_settings(0, 511));
    plan_q.push_back(plan_action(ACT_SET_ALL, 8'd0, 24'h5A5A5A, ResIdleTaken));
    plan_q.push_back(plan_action(ACT_SET_PIXEL, 8'd255, 24'hFFFFFF, ResIdleTaken));
    plan_q.push_back(plan_action(ACT_SET_PIXEL, 8'd0, 24'h000000, ResIdleTaken));
    // Both bit values on a short period; the second LED keeps the fill
    plan_q.push_back(plan_settings(2, 2));
    plan_q.push_back(plan_action(ACT_SET_PIXEL, 8'd0, 24'hC3A55A, ResIdleTaken));
    plan_q.push_back(plan_action(ACT_SHOW, 8'd0, 24'h000000, ResBusyTaken));
    plan_q.push_back(plan_finish());
    // Longest period setting with a full store clear
    plan_q.push_back(plan_settings(1023, 256));
    plan_q.push_back(plan_action(ACT_CLEAR, 8'd0, 24'h000000, ResIdleTaken));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan_q[k]) begin
      case (plan_q[k].kind)
        ROW_ACTION:   push_action(plan_q[k].item, 1'b1, plan_q[k].want);
        ROW_SETTINGS: load_settings(plan_q[k].period, plan_q[k].leds);
        default: begin
          frame_drain_on = 1'b1;
          finish_frame(0);
          frame_drain_on = 1'b0;
        end
      endcase
    end

    // Random phases: new settings, a few store edits, then mostly complete
    // frames with refused actions mixed in; some sequences stop before show.
    // Long chains get store edits only, a frame over them runs for thousands
    // of ticks.
    mark = sent_items;
    while (sent_items - mark < RandomItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        per  = $urandom_range(0, 1);
        leds = $urandom_range(MaxLeds, 511);
      end else begin
        per  = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 2) : $urandom_range(3, 4);
        pick = $urandom_range(0, 19);
        leds = (pick < 2) ? 0 : (pick < 16) ? $urandom_range(1, 2) : $urandom_range(3, 4);
      end
      load_settings(per, leds);
      repeat ($urandom_range(1, 2)) begin
        repeat ($urandom_range(0, 5)) push_action(store_item(), 1'b0, '0);
        if (leds <= MaxShowLeds && $urandom_range(0, 7) != 0) begin
          push_action(any_item(ACT_SHOW), 1'b0, '0);
          finish_frame(5);
        end
      end
    end

    act_ch.valid <= 1'b0;
    while (led_results_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* files.f */
sv/lrs_pkg.sv
sv/lrs_if.sv
sv/lrs_datapath.sv
sv/lrs_ctrl.sv
sv/addressable_rgb_led_serializer_core.sv
dv/tb.sv
